@@ rtl/button_debounce_hold_double_click_macros.svh @@
// assertion macros for the button debounce rtl
// no dependencies; included by files that carry assertions
`ifndef BUTTON_DEBOUNCE_HOLD_DOUBLE_CLICK_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_DOUBLE_CLICK_MACROS_SVH

// same-cycle implication, checked out of reset
`define BDHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BDHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bdhd_pkg.sv @@
// types and constants for the button debounce block
// no dependencies
`timescale 1ns / 1ps

package bdhd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DEB_W  = 16;
    localparam int unsigned IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HOLD     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DOUBLE   = 2'd2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd15;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] double_ms;
    } t_cfg;

    typedef struct packed {
        logic press;
        logic release_ev;
        logic hold;
        logic hold_release;
        logic dbl;
    } t_flags;

endpackage

@@ rtl/bdhd_cfg.sv @@
// configuration registers: debounce, hold and double-click times
// depends on bdhd_pkg
`timescale 1ns / 1ps

module bdhd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [bdhd_pkg::IDX_W-1:0]        i_index,
    input  logic [bdhd_pkg::TIME_W-1:0]       i_data,
    output bdhd_pkg::t_cfg                    o_cfg
);

    bdhd_pkg::t_cfg r_cfg;
    bdhd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                bdhd_pkg::CFG_DEBOUNCE: n_cfg.debounce_ms = i_data[bdhd_pkg::DEB_W-1:0];
                bdhd_pkg::CFG_HOLD:     n_cfg.hold_ms     = i_data;
                bdhd_pkg::CFG_DOUBLE:   n_cfg.double_ms   = i_data;
                default:                n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= bdhd_pkg::DEBOUNCE_RESET;
            r_cfg.hold_ms     <= '0;
            r_cfg.double_ms   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bdhd_eval.sv @@
// button state and the per-poll update of debounce, hold and double click
// depends on bdhd_pkg
`timescale 1ns / 1ps

module bdhd_eval (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic                              i_level,
    input  logic [bdhd_pkg::TIME_W-1:0]       i_now_ms,
    input  bdhd_pkg::t_cfg                    i_cfg,
    output bdhd_pkg::t_flags                  o_flags
);

    logic                        r_stable;
    logic                        r_prev_raw;
    logic [bdhd_pkg::TIME_W-1:0] r_change_time;
    logic [bdhd_pkg::TIME_W-1:0] r_press_time;
    logic [bdhd_pkg::TIME_W-1:0] r_earlier_time;
    logic                        r_holding;
    logic                        r_armed;

    logic                        n_stable;
    logic [bdhd_pkg::TIME_W-1:0] n_change_time;
    logic [bdhd_pkg::TIME_W-1:0] n_press_time;
    logic [bdhd_pkg::TIME_W-1:0] n_earlier_time;
    logic                        n_holding;
    logic                        n_armed;

    logic [bdhd_pkg::TIME_W-1:0] w_since_change;
    logic [bdhd_pkg::TIME_W-1:0] w_since_press;
    logic [bdhd_pkg::TIME_W-1:0] w_gap;
    logic                        w_settled;
    bdhd_pkg::t_flags            w_flags;

    always_comb begin
        n_stable       = r_stable;
        n_press_time   = r_press_time;
        n_earlier_time = r_earlier_time;
        n_holding      = r_holding;
        n_armed        = r_armed;
        w_flags        = '0;

        n_change_time  = (i_level != r_prev_raw) ? i_now_ms : r_change_time;
        w_since_change = i_now_ms - n_change_time;
        w_settled      = (w_since_change > {{(bdhd_pkg::TIME_W-bdhd_pkg::DEB_W){1'b0}},
                                            i_cfg.debounce_ms})
                         && (i_level != r_stable);

        if (w_settled) begin
            n_stable = i_level;
            if (i_level == bdhd_pkg::LEVEL_PRESSED) begin
                w_flags.press = 1'b1;
                n_press_time  = i_now_ms;
            end else begin
                w_flags.release_ev = 1'b1;
                // a release after a double forgets the earlier press so a third
                // click does not count again
                n_earlier_time = r_armed ? '0 : r_press_time;
                n_armed        = 1'b0;
                if (r_holding) begin
                    w_flags.hold_release = 1'b1;
                    n_holding            = 1'b0;
                end
            end
        end

        w_since_press = i_now_ms - n_press_time;
        if ((i_cfg.hold_ms != '0) && (w_since_press > i_cfg.hold_ms)
                && (n_stable == bdhd_pkg::LEVEL_PRESSED) && !n_holding) begin
            n_holding    = 1'b1;
            w_flags.hold = 1'b1;
        end

        // zero double time never passes since an unsigned gap is never below it
        w_gap = n_press_time - n_earlier_time;
        if ((w_gap != '0) && (w_gap < i_cfg.double_ms) && !n_armed && !w_flags.hold) begin
            n_armed     = 1'b1;
            w_flags.dbl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable       <= bdhd_pkg::LEVEL_RELEASED;
            r_prev_raw     <= bdhd_pkg::LEVEL_RELEASED;
            r_change_time  <= '0;
            r_press_time   <= '0;
            r_earlier_time <= '0;
            r_holding      <= 1'b0;
            r_armed        <= 1'b0;
        end else if (i_fire) begin
            r_stable       <= n_stable;
            r_prev_raw     <= i_level;
            r_change_time  <= n_change_time;
            r_press_time   <= n_press_time;
            r_earlier_time <= n_earlier_time;
            r_holding      <= n_holding;
            r_armed        <= n_armed;
        end
    end

    assign o_flags = w_flags;

endmodule

@@ rtl/button_debounce_hold_double_click.sv @@
// channel  | signals                                   | direction
// -------- | ----------------------------------------- | ---------
// poll in  | i_in_valid o_in_ready i_level i_now_ms    | in
// result   | o_out_valid i_out_ready o_*_seen (5 flags) | out
// config   | i_cfg_valid o_cfg_ready i_cfg_index/data  | in
//
// one item per cycle sustained while results are taken; an item sits
// in the input register, its result goes to the output register once
// free; the state update is a single pass of subtract and compare logic
// a stalled result holds the output register; the input register still
// takes an item, further items wait until the result is taken
// synchronous active-low reset puts the button in the released state
// depends on bdhd_pkg, bdhd_cfg, bdhd_eval and the macros header
`timescale 1ns / 1ps
`include "button_debounce_hold_double_click_macros.svh"

module button_debounce_hold_double_click (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_level,
    input  logic [bdhd_pkg::TIME_W-1:0]       i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_press_seen,
    output logic                              o_release_seen,
    output logic                              o_hold_seen,
    output logic                              o_hold_release_seen,
    output logic                              o_double_seen,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdhd_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [bdhd_pkg::TIME_W-1:0]       i_cfg_data
);

    logic                        r_in_valid;
    logic                        r_level;
    logic [bdhd_pkg::TIME_W-1:0] r_now_ms;
    logic                        r_out_valid;
    bdhd_pkg::t_flags            r_flags;

    logic                        n_in_valid;
    logic                        n_out_valid;

    logic                        w_out_free;
    logic                        w_fire;
    logic                        w_in_take;
    bdhd_pkg::t_cfg              w_cfg;
    bdhd_pkg::t_flags            w_flags;

    assign o_cfg_ready = 1'b1;

    bdhd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    bdhd_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_level  (r_level),
        .i_now_ms (r_now_ms),
        .i_cfg    (w_cfg),
        .o_flags  (w_flags)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid  = w_in_take || (r_in_valid && !w_fire);
        n_out_valid = w_fire || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_level  <= i_level;
            r_now_ms <= i_now_ms;
        end
        if (w_fire) begin
            r_flags <= w_flags;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_press_seen        = r_flags.press;
    assign o_release_seen      = r_flags.release_ev;
    assign o_hold_seen         = r_flags.hold;
    assign o_hold_release_seen = r_flags.hold_release;
    assign o_double_seen       = r_flags.dbl;

    `BDHD_ASSERT_NOW(a_no_press_and_release, i_clk, i_rst_n,
        r_out_valid, !(r_flags.press && r_flags.release_ev),
        "press and release in one result")
    `BDHD_ASSERT_NOW(a_hold_release_is_release, i_clk, i_rst_n,
        r_out_valid && r_flags.hold_release, r_flags.release_ev,
        "hold release without a release")
    `BDHD_ASSERT_NOW(a_hold_blocks_double, i_clk, i_rst_n,
        r_out_valid && r_flags.hold, !r_flags.dbl,
        "hold and double in one result")
    `BDHD_ASSERT_NEXT(a_result_follows_fire, i_clk, i_rst_n,
        w_fire, r_out_valid,
        "evaluated item produced no result")
    `BDHD_ASSERT_NOW(a_full_stall_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_out_ready, !o_in_ready,
        "input taken while both registers are full")

endmodule

@@ tb/button_event_checker.sv @@
// checker for the button debounce block: watches the poll, result and config
// channels, predicts the five event flags per poll and compares them in order
// depends on bdhd_pkg
`timescale 1ns / 1ps

module button_event_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_level,
    input  logic [bdhd_pkg::TIME_W-1:0] i_now_ms,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_press_seen,
    input  logic                        i_release_seen,
    input  logic                        i_hold_seen,
    input  logic                        i_hold_release_seen,
    input  logic                        i_double_seen,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [bdhd_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [bdhd_pkg::TIME_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bdhd_pkg::*;

    t_cfg              cfg;
    logic              stable_lvl;
    logic              last_raw;
    logic              hold_marked;
    logic              double_marked;
    logic [TIME_W-1:0] raw_edge_ms;
    logic [TIME_W-1:0] press_ms;
    logic [TIME_W-1:0] prior_press_ms;
    t_flags            event_q[$];
    int                fails = 0;
    int                waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    // one poll of the debouncer, updates the shadow state and returns its flags
    function automatic t_flags debounce_poll(input logic lvl, input logic [TIME_W-1:0] now);
        t_flags            f;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] press_gap;
        f = '0;
        // a raw change restarts the debounce window on the same poll
        if (lvl != last_raw)
            raw_edge_ms = now;
        since_edge = now - raw_edge_ms;
        if (since_edge > cfg.debounce_ms && lvl != stable_lvl) begin
            stable_lvl = lvl;
            if (lvl == LEVEL_PRESSED) begin
                f.press  = 1'b1;
                press_ms = now;
            end else begin
                f.release_ev   = 1'b1;
                prior_press_ms = press_ms;
                // a reported double clears the history so a third click is plain
                if (double_marked) begin
                    double_marked  = 1'b0;
                    prior_press_ms = '0;
                end
                if (hold_marked) begin
                    f.hold_release = 1'b1;
                    hold_marked    = 1'b0;
                end
            end
        end
        since_press = now - press_ms;
        if (cfg.hold_ms != 0 && since_press > cfg.hold_ms &&
            stable_lvl == LEVEL_PRESSED && !hold_marked) begin
            hold_marked = 1'b1;
            f.hold      = 1'b1;
        end
        // checked on every poll, zero gap never counts
        press_gap = press_ms - prior_press_ms;
        if (press_gap != 0 && press_gap < cfg.double_ms && !double_marked && !f.hold) begin
            double_marked = 1'b1;
            f.dbl         = 1'b1;
        end
        last_raw = lvl;
        return f;
    endfunction

    always @(posedge i_clk) begin : watch
        t_flags want;
        t_flags got;
        if (!i_rst_n) begin
            cfg.debounce_ms = DEBOUNCE_RESET;
            cfg.hold_ms     = '0;
            cfg.double_ms   = '0;
            stable_lvl      = LEVEL_RELEASED;
            last_raw        = LEVEL_RELEASED;
            hold_marked     = 1'b0;
            double_marked   = 1'b0;
            raw_edge_ms     = '0;
            press_ms        = '0;
            prior_press_ms  = '0;
            event_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE: cfg.debounce_ms = i_cfg_data[DEB_W-1:0];
                    CFG_HOLD:     cfg.hold_ms     = i_cfg_data;
                    CFG_DOUBLE:   cfg.double_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_press_seen, i_release_seen, i_hold_seen, i_hold_release_seen,
                       i_double_seen};
                if (event_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with no item outstanding, expected none, got %b",
                             $time, got);
                end else begin
                    want = event_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        // flags in order press, release, hold, hold release, double
                        $display("%0t: flags mismatch, expected %b, got %b",
                                 $time, want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                event_q.push_back(debounce_poll(i_level, i_now_ms));
        end
        waiting = event_q.size();
    end

endmodule

@@ tb/tb_button_debounce_hold_double_click.sv @@
// testbench top for the button debounce block: drives polls, register writes
// and result back-pressure with random gaps; checking is in button_event_checker
// depends on bdhd_pkg, button_debounce_hold_double_click and button_event_checker
`timescale 1ns / 1ps

module tb_button_debounce_hold_double_click;
    import bdhd_pkg::*;

    localparam int unsigned RANDOM_POLLS = 400;
    localparam logic [TIME_W-1:0] BASE_MS = 32'h8000_0000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_level;
    logic [TIME_W-1:0] i_now_ms;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_press_seen;
    logic              o_release_seen;
    logic              o_hold_seen;
    logic              o_hold_release_seen;
    logic              o_double_seen;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [TIME_W-1:0] i_cfg_data;

    int                fail_count;
    int                pending;

    logic [TIME_W-1:0] t_ms;
    int unsigned       deb_cfg;
    logic [TIME_W-1:0] hold_cfg;
    logic [TIME_W-1:0] dbl_cfg;
    int unsigned       calm_left;
    int unsigned       n_polls;

    button_debounce_hold_double_click dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_level             (i_level),
        .i_now_ms            (i_now_ms),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_press_seen        (o_press_seen),
        .o_release_seen      (o_release_seen),
        .o_hold_seen         (o_hold_seen),
        .o_hold_release_seen (o_hold_release_seen),
        .o_double_seen       (o_double_seen),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    button_event_checker checker_inst (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_level             (i_level),
        .i_now_ms            (i_now_ms),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_press_seen        (o_press_seen),
        .i_release_seen      (o_release_seen),
        .i_hold_seen         (o_hold_seen),
        .i_hold_release_seen (o_hold_release_seen),
        .i_double_seen       (o_double_seen),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result back-pressure: open stretches, long stalls and random chatter
    initial begin : out_stall
        int unsigned mode;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else if (mode < 4) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(8, 30)) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    i_out_ready = ($urandom_range(0, 2) != 0);
                    @(negedge i_clk);
                end
            end
        end
    end

    // one item on the poll channel; called and returning at a falling edge
    task automatic poll(input logic lvl, input logic [TIME_W-1:0] t);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0)
                calm_left = $urandom_range(20, 50);
            else if (r >= 10 && r < 17)
                gap = $urandom_range(1, 3);
            else if (r >= 17)
                gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_level    = lvl;
        i_now_ms   = t;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        n_polls++;
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] hold,
                             input logic [TIME_W-1:0] dbl);
        settle();
        set_reg(CFG_DEBOUNCE, {16'd0, deb});
        set_reg(CFG_HOLD, hold);
        set_reg(CFG_DOUBLE, dbl);
        deb_cfg  = {16'd0, deb};
        hold_cfg = hold;
        dbl_cfg  = dbl;
    endtask

    // steady level for a bit more than dur ms, polled a handful of times
    task automatic hold_level(input logic lvl, input int unsigned dur);
        logic [TIME_W-1:0] start;
        int unsigned       stride;
        stride = dur / 4 + 1;
        t_ms   = t_ms + $urandom_range(1, 3);
        start  = t_ms;
        poll(lvl, t_ms);
        while (t_ms - start <= dur) begin
            t_ms = t_ms + stride + $urandom_range(0, 2);
            poll(lvl, t_ms);
        end
    endtask

    // contact chatter that ends on the target level
    task automatic bounce(input logic target);
        repeat ($urandom_range(0, 3)) begin
            t_ms = t_ms + $urandom_range(1, 2);
            poll(~target, t_ms);
            t_ms = t_ms + $urandom_range(0, 2);
            poll(target, t_ms);
        end
    endtask

    initial begin : stimulus
        int unsigned n_directed;
        int unsigned r;
        int unsigned press_dur;
        int unsigned rel_dur;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_level     = LEVEL_RELEASED;
        i_now_ms    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEBOUNCE;
        i_cfg_data  = '0;
        calm_left   = 0;
        n_polls     = 0;
        t_ms        = '0;
        deb_cfg     = {16'd0, DEBOUNCE_RESET};
        hold_cfg    = '0;
        dbl_cfg     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: press across the time wrap, chatter, plain release
        poll(LEVEL_RELEASED, 32'h0000_0000);
        poll(LEVEL_PRESSED, 32'hFFFF_FFF0);
        poll(LEVEL_PRESSED, 32'h0000_0000);
        poll(LEVEL_RELEASED, 32'h0000_0005);
        poll(LEVEL_PRESSED, 32'h0000_0006);
        poll(LEVEL_RELEASED, 32'h0000_0020);
        poll(LEVEL_RELEASED, 32'h0000_0031);

        // zero debounce: no press on the raw change poll, then hold, double, triple
        configure(16'd0, 32'd10, 32'd100);
        poll(LEVEL_PRESSED, BASE_MS);
        poll(LEVEL_PRESSED, BASE_MS + 1);
        poll(LEVEL_PRESSED, BASE_MS + 12);
        poll(LEVEL_RELEASED, BASE_MS + 13);
        poll(LEVEL_RELEASED, BASE_MS + 14);
        poll(LEVEL_PRESSED, BASE_MS + 20);
        poll(LEVEL_PRESSED, BASE_MS + 21);
        poll(LEVEL_RELEASED, BASE_MS + 22);
        poll(LEVEL_RELEASED, BASE_MS + 23);
        poll(LEVEL_PRESSED, BASE_MS + 30);
        poll(LEVEL_PRESSED, BASE_MS + 31);
        poll(LEVEL_RELEASED, BASE_MS + 32);
        poll(LEVEL_RELEASED, BASE_MS + 33);

        // largest settings: exactly debounce_ms is not enough
        configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        poll(LEVEL_PRESSED, 32'h7FFF_0000);
        poll(LEVEL_PRESSED, 32'h7FFF_0000 + 65535);
        poll(LEVEL_PRESSED, 32'h7FFF_0000 + 65536);
        t_ms = 32'h7FFF_0000 + 65536;

        n_directed = n_polls;
        while (n_polls < n_directed + RANDOM_POLLS) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else if (r == 1)
                configure(16'd0, $urandom_range(0, 1), $urandom_range(0, 1));
            else
                configure(DEB_W'($urandom_range(0, 20)),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(20, 200),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(40, 400));
            if ($urandom_range(0, 1))
                t_ms = $urandom;
            repeat ($urandom_range(3, 8)) begin
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    // well-formed click, long enough for hold about half the time when a short hold time is set
                    press_dur = deb_cfg + 1 + $urandom_range(0, 30);
                    if (hold_cfg != 0 && hold_cfg < 100000 && $urandom_range(0, 1))
                        press_dur = deb_cfg + hold_cfg + $urandom_range(1, 40);
                    rel_dur = deb_cfg + 1 + $urandom_range(0, 40);
                    if (dbl_cfg != 0 && dbl_cfg < 100000 && $urandom_range(0, 2) != 0)
                        rel_dur = deb_cfg + 1 + $urandom_range(0, dbl_cfg);
                    bounce(LEVEL_PRESSED);
                    hold_level(LEVEL_PRESSED, press_dur);
                    bounce(LEVEL_RELEASED);
                    hold_level(LEVEL_RELEASED, rel_dur);
                end else if (r < 17) begin
                    repeat ($urandom_range(1, 4)) begin
                        t_ms = t_ms + $urandom_range(0, 3);
                        poll(1'($urandom_range(0, 1)), t_ms);
                    end
                end else if (r < 19) begin
                    // press that ends before the debounce window
                    t_ms = t_ms + 1;
                    poll(LEVEL_PRESSED, t_ms);
                    t_ms = t_ms + $urandom_range(0, deb_cfg);
                    poll(LEVEL_PRESSED, t_ms);
                    t_ms = t_ms + 1;
                    poll(LEVEL_RELEASED, t_ms);
                end else begin
                    t_ms = t_ms + $urandom;
                    poll(1'($urandom_range(0, 1)), t_ms);
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_button_debounce_hold_double_click: PASS");
        else
            $display("tb_button_debounce_hold_double_click: FAIL");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_button_debounce_hold_double_click: FAIL");
        $finish;
    end

endmodule
